/* hdl/plac_pkg.sv */
// ----------------------------------------------------------------------------
// plac_pkg: shared types and constants of the path length accumulator
// Holds the position, square, root and sum widths, the control state
// encoding and the status bundle of the iterative square root unit.
// ----------------------------------------------------------------------------
package plac_pkg;

  localparam int POS_WIDTH = 24;
  localparam int SUM_WIDTH = 48;
  localparam int VEL_WIDTH = 16;
  localparam int DIST_WIDTH = 48;

  localparam int SQ_WIDTH = 2 * POS_WIDTH;
  localparam int RAD_WIDTH = 2 * POS_WIDTH + 2;
  localparam int ROOT_WIDTH = POS_WIDTH + 1;
  localparam int REM_WIDTH = ROOT_WIDTH + 3;
  localparam int CNT_WIDTH = $clog2(ROOT_WIDTH + 1);

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [SQ_WIDTH-1:0] sq_t;
  typedef logic [RAD_WIDTH-1:0] rad_t;
  typedef logic [ROOT_WIDTH-1:0] root_t;
  typedef logic [SUM_WIDTH-1:0] sum_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_WAIT = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_HOLD = 7'b1000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

/* hdl/plac_sqrt.sv */
// ----------------------------------------------------------------------------
// plac_sqrt: iterative integer square root
// Digit-by-digit floor square root that retires one root bit per cycle
// through a single compare and subtract unit.
// ----------------------------------------------------------------------------
module plac_sqrt
  import plac_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  rad_t         radicand,
  output sqrt_status_t status,
  output root_t        root
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  rad_t                 rad_r, rad_nxt;
  logic [REM_WIDTH-1:0] rem_r, rem_nxt;
  root_t                root_r, root_nxt;

  logic [REM_WIDTH-1:0] rem_sh;
  logic [REM_WIDTH-1:0] trial;

  assign rem_sh = {rem_r[REM_WIDTH-3:0], rad_r[RAD_WIDTH-1 -: 2]};
  assign trial  = {(REM_WIDTH-2)'(root_r), 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_WIDTH'(ROOT_WIDTH);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_WIDTH-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign root        = root_r;

endmodule

/* hdl/path_length_accumulator.sv */
// ----------------------------------------------------------------------------
// path_length_accumulator: Euclidean path length of planar odometry
// Adds the floor of the distance between successive positions to a
// saturating running total and returns it with the velocity of each sample.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    pos_x, pos_y, forward_velocity
//   out_     output     out_valid / out_ready  total_distance, velocity_out
//
// After acceptance the squares share one multiplier in S_SQX and S_SQY,
// then S_ROOT starts the bit-serial square root that retires one of its
// 25 root bits per cycle while S_WAIT waits, and S_ACC loads the result.
// The first sample after reset adds nothing and goes straight to S_ACC.
// Reset is synchronous and active low and clears the total and the history.
// The result sits in an output register, so the next word is accepted while
// it waits; a new result waits in the final stage until that register frees.
// ----------------------------------------------------------------------------
module path_length_accumulator
  import plac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_WIDTH-1:0]  in_pos_x,
  input  logic [POS_WIDTH-1:0]  in_pos_y,
  input  logic [VEL_WIDTH-1:0]  in_forward_velocity,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_WIDTH-1:0] out_total_distance,
  output logic [VEL_WIDTH-1:0]  out_velocity_out
);

  state_t               state_r, state_nxt;
  logic                 have_prev_r, have_prev_nxt;
  pos_t                 last_x_r, last_y_r;
  pos_t                 dx_r, dy_r;
  sq_t                  sqx_r;
  rad_t                 rad_r;
  sum_t                 sum_r, sum_nxt;
  logic                 step_en_r;
  logic [VEL_WIDTH-1:0] vel_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIST_WIDTH-1:0] out_dist_r;
  logic [VEL_WIDTH-1:0] out_vel_r;

  logic                 accept;
  logic                 load_out;
  logic signed [POS_WIDTH:0] diff_x, diff_y;
  pos_t                 mul_op;
  sq_t                  product;
  sqrt_status_t         sq_status;
  root_t                root;
  logic [SUM_WIDTH:0]   sum_add;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_ACC) && (!out_valid_r || out_ready);

  assign diff_x = $signed({in_pos_x[POS_WIDTH-1], in_pos_x})
                - $signed({last_x_r[POS_WIDTH-1], last_x_r});
  assign diff_y = $signed({in_pos_y[POS_WIDTH-1], in_pos_y})
                - $signed({last_y_r[POS_WIDTH-1], last_y_r});

  assign mul_op  = (state_r == S_SQX) ? dx_r : dy_r;
  assign product = SQ_WIDTH'(mul_op) * SQ_WIDTH'(mul_op);

  plac_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_ROOT),
    .radicand (rad_r),
    .status   (sq_status),
    .root     (root)
  );

  always_comb begin
    sum_add = {1'b0, sum_r} + (SUM_WIDTH + 1)'(root);
    sum_nxt = sum_r;
    if (load_out && step_en_r) begin
      sum_nxt = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          have_prev_nxt = 1'b1;
          state_nxt     = have_prev_r ? S_SQX : S_ACC;
        end
      end
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_ROOT;
      S_ROOT: state_nxt = S_WAIT;
      S_WAIT: begin
        if (sq_status.done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_HOLD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      if (accept) begin
        last_x_r <= in_pos_x;
        last_y_r <= in_pos_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r      <= diff_x[POS_WIDTH] ? POS_WIDTH'(-diff_x) : diff_x[POS_WIDTH-1:0];
      dy_r      <= diff_y[POS_WIDTH] ? POS_WIDTH'(-diff_y) : diff_y[POS_WIDTH-1:0];
      vel_r     <= in_forward_velocity;
      step_en_r <= have_prev_r;
    end
    if (state_r == S_SQX) begin
      sqx_r <= product;
    end
    if (state_r == S_SQY) begin
      rad_r <= RAD_WIDTH'(sqx_r) + RAD_WIDTH'(product);
    end
    if (load_out) begin
      out_dist_r <= DIST_WIDTH'(sum_nxt);
      out_vel_r  <= vel_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_total_distance = out_dist_r;
  assign out_velocity_out   = out_vel_r;

endmodule
